// ===== hw/rtl/rztp_pkg.sv =====
// ---------------------------------------------------------------------------
// rztp_pkg
// Shared types and constants for the Z-rotation plus translation point block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rztp_pkg;

   localparam int COORD_WIDTH  = 32;   // Q16.16 coordinates
   localparam int ANGLE_WIDTH  = 16;   // binary angle, full scale is one turn
   localparam int TRIG_WIDTH   = 17;   // Q1.15 widened so +1.0 fits
   localparam int TURN_WIDTH   = 32;   // internal turn fraction
   localparam int CORDIC_WIDTH = 34;   // Q2.30 with headroom
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_WIDTH   = $clog2(CORDIC_STEPS);
   localparam int TRIG_FRAC    = 15;
   localparam int DATA_WIDTH   = 32;
   localparam int ADDR_WIDTH   = 4;

   localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_X_START = 34'sd652032874;
   localparam logic signed [TRIG_WIDTH-1:0]   TRIG_ONE       = 17'sd32768;
   localparam logic signed [TRIG_WIDTH-1:0]   TRIG_ZERO      = 17'sd0;

   localparam logic [TURN_WIDTH-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [1:0] {
      REG_HEADING,
      REG_OFFSET_X,
      REG_OFFSET_Y,
      REG_OFFSET_Z
   } csr_index_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_ROTATE,
      SC_FINISH
   } sincos_state_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] result_x;
      logic signed [COORD_WIDTH-1:0] result_y;
      logic signed [COORD_WIDTH-1:0] result_z;
      logic                          saturated;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/rztp_sincos.sv =====
// ---------------------------------------------------------------------------
// rztp_sincos
// Iterative CORDIC that forms Q1.15 cosine and sine of the heading, one
// micro-rotation per cycle, then rounds, clamps and folds in the quadrant.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rztp_sincos (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [rztp_pkg::ANGLE_WIDTH-1:0]       heading_in,
   output logic                                   busy,
   output logic signed [rztp_pkg::TRIG_WIDTH-1:0] cos_q15,
   output logic signed [rztp_pkg::TRIG_WIDTH-1:0] sin_q15
);

   localparam int CW = rztp_pkg::CORDIC_WIDTH;
   localparam int TW = rztp_pkg::TRIG_WIDTH;
   localparam int RW = CW - rztp_pkg::TRIG_FRAC;

   function automatic logic signed [TW-1:0] clamp_q15(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] hi;
      logic signed [RW-1:0] lo;
      hi = RW'(32768);
      lo = -hi;
      if (v > hi) begin
         return rztp_pkg::TRIG_ONE;
      end else if (v < lo) begin
         return -rztp_pkg::TRIG_ONE;
      end
      return v[TW-1:0];
   endfunction

   rztp_pkg::sincos_state_type state_ff, state_in;

   logic signed [CW-1:0]                  x_ff, x_in;
   logic signed [CW-1:0]                  y_ff, y_in;
   logic signed [CW-1:0]                  z_ff, z_in;
   logic [rztp_pkg::STEP_WIDTH-1:0]       step_ff, step_in;
   logic [1:0]                            quad_ff, quad_in;
   logic                                  zero_ff, zero_in;
   logic signed [TW-1:0]                  cos_ff, cos_in;
   logic signed [TW-1:0]                  sin_ff, sin_in;

   logic [rztp_pkg::TURN_WIDTH-1:0]       angle;
   logic [rztp_pkg::TURN_WIDTH-1:0]       angle_bias;
   logic [rztp_pkg::TURN_WIDTH-1:0]       residual;
   logic signed [CW-1:0]                  dx;
   logic signed [CW-1:0]                  dy;
   logic signed [CW-1:0]                  da;
   logic signed [CW-1:0]                  x_rnd;
   logic signed [CW-1:0]                  y_rnd;
   logic signed [TW-1:0]                  c_val;
   logic signed [TW-1:0]                  s_val;

   assign angle      = {heading_in, {(rztp_pkg::TURN_WIDTH-rztp_pkg::ANGLE_WIDTH){1'b0}}};
   assign angle_bias = angle + 32'h2000_0000;
   assign residual   = angle - {angle_bias[31:30], 30'd0};

   assign dx    = y_ff >>> step_ff;
   assign dy    = x_ff >>> step_ff;
   assign da    = $signed({2'b00, rztp_pkg::ATAN_TABLE[step_ff]});
   assign x_rnd = x_ff + CW'(16384);
   assign y_rnd = y_ff + CW'(16384);
   assign c_val = clamp_q15(x_rnd[CW-1:rztp_pkg::TRIG_FRAC]);
   assign s_val = clamp_q15(y_rnd[CW-1:rztp_pkg::TRIG_FRAC]);

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      quad_in  = quad_ff;
      zero_in  = zero_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      unique case (state_ff)
         rztp_pkg::SC_IDLE: ;
         rztp_pkg::SC_ROTATE: begin
            if (!z_ff[CW-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - da;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + da;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == rztp_pkg::STEP_WIDTH'(rztp_pkg::CORDIC_STEPS - 1)) begin
               state_in = rztp_pkg::SC_FINISH;
            end
         end
         rztp_pkg::SC_FINISH: begin
            // fold the quadrant back in; zero heading is an exact identity
            if (zero_ff) begin
               cos_in = rztp_pkg::TRIG_ONE;
               sin_in = rztp_pkg::TRIG_ZERO;
            end else begin
               case (quad_ff)
                  2'd0: begin cos_in = c_val;  sin_in = s_val;  end
                  2'd1: begin cos_in = -s_val; sin_in = c_val;  end
                  2'd2: begin cos_in = -c_val; sin_in = -s_val; end
                  default: begin cos_in = s_val; sin_in = -c_val; end
               endcase
            end
            state_in = rztp_pkg::SC_IDLE;
         end
         default: begin
            state_in = rztp_pkg::SC_IDLE;
         end
      endcase
      // a new heading restarts the rotation from any state
      if (start) begin
         x_in     = rztp_pkg::CORDIC_X_START;
         y_in     = '0;
         z_in     = $signed({{(CW-rztp_pkg::TURN_WIDTH){residual[31]}}, residual});
         step_in  = '0;
         quad_in  = angle_bias[31:30];
         zero_in  = (heading_in == '0);
         state_in = rztp_pkg::SC_ROTATE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rztp_pkg::SC_IDLE;
         cos_ff   <= rztp_pkg::TRIG_ONE;
         sin_ff   <= rztp_pkg::TRIG_ZERO;
      end else begin
         state_ff <= state_in;
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      quad_ff <= quad_in;
      zero_ff <= zero_in;
   end

   assign busy    = (state_ff != rztp_pkg::SC_IDLE);
   assign cos_q15 = cos_ff;
   assign sin_q15 = sin_ff;

endmodule

// ===== hw/rtl/rotate_z_translate_point.sv =====
// ---------------------------------------------------------------------------
// rotate_z_translate_point
// Rotates a Q16.16 point about Z by the heading and adds the offsets.
// Request beats pass the input, product and result registers in order.
// Throughput: one point per cycle, set by the three-stage elastic pipeline,
// while no heading write reruns the 24-step CORDIC and the responses drain.
// Reset (synchronous): pipeline empty, registers zero, cos = 1.0, sin = 0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotate_z_translate_point (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rztp_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rztp_pkg::rsp_payload_type           rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rztp_pkg::ADDR_WIDTH-1:0]     paddr,
   input  logic [rztp_pkg::DATA_WIDTH-1:0]     pwdata,
   output logic [rztp_pkg::DATA_WIDTH-1:0]     prdata,
   output logic                                pready
);

   localparam int CW  = rztp_pkg::COORD_WIDTH;
   localparam int PW  = CW + rztp_pkg::TRIG_WIDTH;
   localparam int SW  = PW + 1;
   localparam int RW  = SW - rztp_pkg::TRIG_FRAC;
   localparam int TOW = RW + 1;

   function automatic logic signed [CW:0] saturate(input logic signed [TOW-1:0] v);
      logic signed [TOW-1:0] hi;
      logic signed [TOW-1:0] lo;
      hi = TOW'({1'b0, {(CW-1){1'b1}}});
      lo = -hi - TOW'(1);
      if (v > hi) begin
         return {1'b1, hi[CW-1:0]};
      end else if (v < lo) begin
         return {1'b1, lo[CW-1:0]};
      end
      return {1'b0, v[CW-1:0]};
   endfunction

   // configuration registers
   logic [rztp_pkg::ANGLE_WIDTH-1:0] heading_ff, heading_in;
   logic signed [CW-1:0]             offset_x_ff, offset_x_in;
   logic signed [CW-1:0]             offset_y_ff, offset_y_in;
   logic signed [CW-1:0]             offset_z_ff, offset_z_in;

   rztp_pkg::csr_index_type          csr_index;
   logic                             csr_write;
   logic                             heading_write;
   logic                             sc_busy;
   logic signed [rztp_pkg::TRIG_WIDTH-1:0] cos_q15;
   logic signed [rztp_pkg::TRIG_WIDTH-1:0] sin_q15;

   assign csr_index     = rztp_pkg::csr_index_type'(paddr[3:2]);
   assign csr_write     = psel && penable && pwrite && pready;
   assign heading_write = csr_write && (csr_index == rztp_pkg::REG_HEADING);
   assign pready        = 1'b1;

   always_comb begin
      heading_in  = heading_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      offset_z_in = offset_z_ff;
      if (csr_write) begin
         unique case (csr_index)
            rztp_pkg::REG_HEADING:  heading_in  = pwdata[rztp_pkg::ANGLE_WIDTH-1:0];
            rztp_pkg::REG_OFFSET_X: offset_x_in = pwdata[CW-1:0];
            rztp_pkg::REG_OFFSET_Y: offset_y_in = pwdata[CW-1:0];
            rztp_pkg::REG_OFFSET_Z: offset_z_in = pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rztp_pkg::REG_HEADING:
            prdata = {{(rztp_pkg::DATA_WIDTH-rztp_pkg::ANGLE_WIDTH){1'b0}}, heading_ff};
         rztp_pkg::REG_OFFSET_X: prdata = offset_x_ff;
         rztp_pkg::REG_OFFSET_Y: prdata = offset_y_ff;
         rztp_pkg::REG_OFFSET_Z: prdata = offset_z_ff;
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff  <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
      end else begin
         heading_ff  <= heading_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         offset_z_ff <= offset_z_in;
      end
   end

   rztp_sincos u_sincos (
      .clock      (clock),
      .reset      (reset),
      .start      (heading_write),
      .heading_in (pwdata[rztp_pkg::ANGLE_WIDTH-1:0]),
      .busy       (sc_busy),
      .cos_q15    (cos_q15),
      .sin_q15    (sin_q15)
   );

   // pipeline: input register, product register, result register
   rztp_pkg::req_payload_type  pt_ff;
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [PW-1:0]       prod_xc_ff, prod_ys_ff, prod_xs_ff, prod_yc_ff;
   logic signed [CW-1:0]       pz_ff;
   logic                       s2_valid_ff, s2_valid_in;
   rztp_pkg::rsp_payload_type  rsp_ff, rsp_in;
   logic                       s3_valid_ff, s3_valid_in;

   logic s1_ready, s2_ready, s3_ready;
   logic req_fire, s1_move, s2_move;

   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready && !sc_busy && !heading_write;
   assign req_fire  = req_valid && req_ready;
   assign s1_move   = s1_valid_ff && s2_ready;
   assign s2_move   = s2_valid_ff && s3_ready;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s1_move  || (s2_valid_ff && !s3_ready);
   assign s3_valid_in = s2_move  || (s3_valid_ff && !rsp_ready);

   logic signed [PW-1:0] px_ext, py_ext, cos_ext, sin_ext;
   assign px_ext  = PW'(pt_ff.point_x);
   assign py_ext  = PW'(pt_ff.point_y);
   assign cos_ext = PW'(cos_q15);
   assign sin_ext = PW'(sin_q15);

   logic signed [SW-1:0]  sum_x, sum_y;
   logic signed [TOW-1:0] tot_x, tot_y, tot_z;
   logic signed [CW:0]    sat_x, sat_y, sat_z;

   // round half up on the Q15 product sums, then translate and clamp
   always_comb begin
      sum_x = SW'(prod_xc_ff) - SW'(prod_ys_ff) + SW'(16384);
      sum_y = SW'(prod_xs_ff) + SW'(prod_yc_ff) + SW'(16384);
      tot_x = TOW'($signed(sum_x[SW-1:rztp_pkg::TRIG_FRAC])) + TOW'(offset_x_ff);
      tot_y = TOW'($signed(sum_y[SW-1:rztp_pkg::TRIG_FRAC])) + TOW'(offset_y_ff);
      tot_z = TOW'(pz_ff) + TOW'(offset_z_ff);
      sat_x = saturate(tot_x);
      sat_y = saturate(tot_y);
      sat_z = saturate(tot_z);
      rsp_in.result_x  = sat_x[CW-1:0];
      rsp_in.result_y  = sat_y[CW-1:0];
      rsp_in.result_z  = sat_z[CW-1:0];
      rsp_in.saturated = sat_x[CW] || sat_y[CW] || sat_z[CW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pt_ff <= req_payload;
      end
      if (s1_move) begin
         prod_xc_ff <= px_ext * cos_ext;
         prod_ys_ff <= py_ext * sin_ext;
         prod_xs_ff <= px_ext * sin_ext;
         prod_yc_ff <= py_ext * cos_ext;
         pz_ff      <= pt_ff.point_z;
      end
      // hold the result beat until it is taken
      if (s2_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = s3_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
